FILE: rtl/fba_pkg.sv
package fba_pkg;

  localparam int OFFSET_W = 20;
  localparam int SIZE_W   = 13;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ZERO       = 3'd1;
  localparam status_t ST_TOO_LARGE  = 3'd2;
  localparam status_t ST_EMPTY      = 3'd3;
  localparam status_t ST_RANGE      = 3'd4;
  localparam status_t ST_MISALIGNED = 3'd5;
  localparam status_t ST_OVERFREE   = 3'd6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

endpackage

FILE: rtl/fba_div.sv
module fba_div #(
  parameter int IW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fba_pkg::OFFSET_W-1:0]  dividend,
  input  logic [fba_pkg::SIZE_W-1:0]    divisor,
  output logic                          done,
  output logic [IW-1:0]                 quot,
  output logic                          rem_zero
);
  import fba_pkg::*;

  localparam int DW = SIZE_W + IW;
  localparam int SW = $clog2(IW) + 1;

  logic [OFFSET_W-1:0] rem;
  logic [DW-1:0]       dsr;
  logic [SW-1:0]       cnt;
  logic                busy;
  logic                ge;
  logic [IW-1:0]       quot_next;

  always_comb begin
    ge = rem >= dsr;
    quot_next = quot << 1;
    quot_next[0] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsr  <= DW'(divisor) << (IW - 1);
        quot <= '0;
        cnt  <= SW'(IW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - OFFSET_W'(dsr);
        end
        dsr  <= dsr >> 1;
        quot <= quot_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rem_zero = (rem == '0);

endmodule

FILE: rtl/fixed_block_free_list_allocator_unit.sv
// A successful allocate passes check and link read (S_ALLOC), update (S_POP), output (S_DONE).
// A rejected allocate or a null free goes from its check to output, an out-of-range free after
// a range check, any other free after the range check, the bit-serial index divider and S_CHK.
// One item is worked on at a time; the next item is taken the cycle after a result is registered,
// and an unaccepted waiting result holds the next result (and so acceptance) in S_DONE.
// Reset and every configuration write rebuild all block_count link entries in S_CLEAR, no items.
module fixed_block_free_list_allocator_unit #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [fba_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // request_bytes[12:0], block_offset[32:13], zero padding
  input  logic [39:0]                  s_axis_tdata,
  // opcode[0], is_null[1]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status[2:0], granted_offset[22:3], free_blocks[31:23]
  output logic [31:0]                  m_axis_tdata
);
  import fba_pkg::*;

  localparam int IW       = $clog2(MAX_BLOCKS);
  localparam int PW       = IW + SIZE_W;
  localparam int LW       = COUNT_W + SIZE_W;
  localparam int SIZE_RST = (64 > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : 64;
  localparam int CNT_RST  = (256 > MAX_BLOCKS) ? MAX_BLOCKS : 256;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_POP, S_FREE, S_RANGE, S_DIV, S_CHK, S_DONE
  } state_t;

  state_t               state;
  logic [SIZE_W-1:0]    block_size;
  logic [COUNT_W-1:0]   block_count;
  logic [IW-1:0]        head;
  logic                 head_valid;
  logic [COUNT_W-1:0]   free_total;
  logic [IW-1:0]        clr_idx;

  logic [SIZE_W-1:0]    in_req;
  logic [OFFSET_W-1:0]  in_offset;
  logic                 in_null;

  logic [PW-1:0]        prod;
  logic [LW-1:0]        limit;
  status_t              res_status;
  logic [OFFSET_W-1:0]  res_grant;

  logic [IW:0]          link_mem [MAX_BLOCKS];
  logic [IW:0]          link_rd;
  logic                 mem_we;
  logic [IW-1:0]        mem_addr;
  logic [IW:0]          mem_wdata;

  logic                 div_start;
  logic                 div_done;
  logic [IW-1:0]        div_quot;
  logic                 div_rem_zero;

  logic [SIZE_W-1:0]    size_next;
  logic [COUNT_W-1:0]   count_next;
  logic                 clr_link_valid;
  logic                 clr_last;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    size_next = cfg_data;
    if (size_next == '0) begin
      size_next = SIZE_W'(1);
    end else if (size_next > MAX_BLOCK_BYTES) begin
      size_next = SIZE_W'(MAX_BLOCK_BYTES);
    end
    count_next = cfg_data[COUNT_W-1:0];
    if (count_next == '0) begin
      count_next = COUNT_W'(1);
    end else if (count_next > MAX_BLOCKS) begin
      count_next = COUNT_W'(MAX_BLOCKS);
    end
  end

  always_comb begin
    clr_link_valid = (int'(clr_idx) + 1) < int'(block_count);
    clr_last       = !clr_link_valid;
    mem_we    = 1'b0;
    mem_addr  = head;
    mem_wdata = {head_valid, head};
    priority if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_idx;
      mem_wdata = {clr_link_valid, clr_link_valid ? IW'(clr_idx + 1'b1) : IW'(0)};
    end else if (state == S_CHK) begin
      mem_we   = div_rem_zero && (free_total < block_count);
      mem_addr = div_quot;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_addr] <= mem_wdata;
    end
    link_rd <= link_mem[mem_addr];
  end

  assign div_start = (state == S_RANGE) && (in_offset < limit);

  fba_div #(
    .IW(IW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_offset),
    .divisor  (block_size),
    .done     (div_done),
    .quot     (div_quot),
    .rem_zero (div_rem_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      block_size    <= SIZE_W'(SIZE_RST);
      block_count   <= COUNT_W'(CNT_RST);
      head          <= '0;
      head_valid    <= 1'b1;
      free_total    <= COUNT_W'(CNT_RST);
      clr_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE || cfg_we)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BLOCK_SIZE: begin
            block_size <= size_next;
            free_total <= block_count;
          end
          REG_BLOCK_COUNT: begin
            block_count <= count_next;
            free_total  <= count_next;
          end
          default: begin
          end
        endcase
        head       <= '0;
        head_valid <= 1'b1;
        clr_idx    <= '0;
        state      <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_idx <= clr_idx + 1'b1;
            if (clr_last) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              in_null   <= s_axis_tuser[1];
              in_req    <= s_axis_tdata[SIZE_W-1:0];
              in_offset <= s_axis_tdata[SIZE_W +: OFFSET_W];
              state     <= (s_axis_tuser[0] == OP_FREE) ? S_FREE : S_ALLOC;
            end
          end
          S_ALLOC: begin
            res_grant <= '0;
            prod      <= PW'(head) * PW'(block_size);
            priority if (in_req == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else if (in_req > block_size) begin
              res_status <= ST_TOO_LARGE;
              state      <= S_DONE;
            end else if (free_total == '0 || !head_valid) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_POP;
            end
          end
          S_POP: begin
            res_grant  <= OFFSET_W'(prod);
            head       <= link_rd[IW-1:0];
            head_valid <= link_rd[IW];
            free_total <= free_total - 1'b1;
            state      <= S_DONE;
          end
          S_FREE: begin
            res_grant  <= '0;
            res_status <= ST_OK;
            limit      <= LW'(block_count) * LW'(block_size);
            state      <= in_null ? S_DONE : S_RANGE;
          end
          S_RANGE: begin
            if (in_offset >= limit) begin
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
          S_DIV: begin
            if (div_done) begin
              state <= S_CHK;
            end
          end
          S_CHK: begin
            priority if (!div_rem_zero) begin
              res_status <= ST_MISALIGNED;
            end else if (free_total >= block_count) begin
              res_status <= ST_OVERFREE;
            end else begin
              res_status <= ST_OK;
              head       <= div_quot;
              head_valid <= 1'b1;
              free_total <= free_total + 1'b1;
            end
            state <= S_DONE;
          end
          S_DONE: begin
            if (!m_axis_tvalid || m_axis_tready) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= {free_total, res_grant, res_status};
              state         <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= block_count)
    else $error("free count exceeds block count");

  a_head_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && head_valid && free_total != '0) |-> (int'(head) < int'(block_count)))
    else $error("free list head outside the pool");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != S_IDLE))
    else $error("accepted item not taken into work");

  a_done_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && !cfg_we) |=> (state == S_DONE))
    else $error("free check did not complete");
`endif

endmodule
